// ===== sv/nec_ir_frame_decoder_unit_defines.svh =====
// Assertion macros for the NEC IR frame decoder.
`ifndef NEC_IR_FRAME_DECODER_UNIT_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_UNIT_DEFINES_SVH

// Check while out of reset.
`define NIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define NIR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/nir_pkg.sv =====
// Types, codes and constants of the NEC IR frame decoder.
package nir_pkg;

	localparam int CODE_W = 32;
	localparam int TICK_W = 16;
	localparam int CFG_IDX_W = 8;

	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_TIMEOUT = 1'b1;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_REPEAT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_BURST_MIN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_MAX = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX = 8'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REP_MIN = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REP_MAX = 8'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 8'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 8'd7;

	localparam logic [TICK_W-1:0] RST_BURST_MIN = 16'd8000;
	localparam logic [TICK_W-1:0] RST_BURST_MAX = 16'd10000;
	localparam logic [TICK_W-1:0] RST_GAP_MIN = 16'd4000;
	localparam logic [TICK_W-1:0] RST_GAP_MAX = 16'd5000;
	localparam logic [TICK_W-1:0] RST_REP_MIN = 16'd2000;
	localparam logic [TICK_W-1:0] RST_REP_MAX = 16'd2500;
	localparam logic [TICK_W-1:0] RST_ZERO_MIN = 16'd400;
	localparam logic [TICK_W-1:0] RST_ZERO_MAX = 16'd700;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_BURST = 3'd1,
		ST_GAP = 3'd2,
		ST_DATA = 3'd3,
		ST_FINISH = 3'd4
	} nir_state_t;

	typedef struct packed {
		logic req_type;
		logic pin_level;
		logic [TICK_W-1:0] elapsed_count;
	} nir_req_t;

	typedef struct packed {
		logic frame_kind;
		logic [CODE_W-1:0] raw_code;
	} nir_res_t;

	typedef struct packed {
		logic [TICK_W-1:0] burst_min;
		logic [TICK_W-1:0] burst_max;
		logic [TICK_W-1:0] gap_min;
		logic [TICK_W-1:0] gap_max;
		logic [TICK_W-1:0] rep_min;
		logic [TICK_W-1:0] rep_max;
		logic [TICK_W-1:0] zero_min;
		logic [TICK_W-1:0] zero_max;
	} nir_cfg_t;

	typedef struct packed {
		nir_state_t state;
		logic [CODE_W-1:0] shift_bits;
		logic [CODE_W-1:0] last_code;
	} nir_ctx_t;

	function automatic logic in_window(input logic [TICK_W-1:0] t,
			input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] hi);
		in_window = (t > lo) && (t < hi);
	endfunction

endpackage

// ===== sv/nir_cfg_regs.sv =====
// Timing window registers of the NEC IR frame decoder.
module nir_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [nir_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [nir_pkg::TICK_W-1:0] wr_data,
	output nir_pkg::nir_cfg_t cfg
);
	import nir_pkg::*;

	nir_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_min <= RST_BURST_MIN;
			cfg_q.burst_max <= RST_BURST_MAX;
			cfg_q.gap_min <= RST_GAP_MIN;
			cfg_q.gap_max <= RST_GAP_MAX;
			cfg_q.rep_min <= RST_REP_MIN;
			cfg_q.rep_max <= RST_REP_MAX;
			cfg_q.zero_min <= RST_ZERO_MIN;
			cfg_q.zero_max <= RST_ZERO_MAX;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_BURST_MIN: cfg_q.burst_min <= wr_data;
				CFG_BURST_MAX: cfg_q.burst_max <= wr_data;
				CFG_GAP_MIN: cfg_q.gap_min <= wr_data;
				CFG_GAP_MAX: cfg_q.gap_max <= wr_data;
				CFG_REP_MIN: cfg_q.rep_min <= wr_data;
				CFG_REP_MAX: cfg_q.rep_max <= wr_data;
				CFG_ZERO_MIN: cfg_q.zero_min <= wr_data;
				CFG_ZERO_MAX: cfg_q.zero_max <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/nir_step.sv =====
// Per-item decode logic: next state, shift update and result.
module nir_step #(
	parameter int FRAME_BITS = 32,
	localparam int CNT_W = $clog2(FRAME_BITS + 1)
) (
	input nir_pkg::nir_cfg_t cfg,
	input nir_pkg::nir_req_t item,
	input nir_pkg::nir_ctx_t ctx,
	input logic [CNT_W-1:0] bit_count,
	output nir_pkg::nir_ctx_t ctx_next,
	output logic [CNT_W-1:0] bit_count_next,
	output logic res_valid,
	output nir_pkg::nir_res_t res
);
	import nir_pkg::*;

	logic burst_ok;
	logic gap_ok;
	logic rep_ok;
	logic zero_ok;
	logic pin;
	logic [CNT_W-1:0] cnt_inc;
	logic last_bit;
	nir_state_t state_next;
	logic [CODE_W-1:0] shift_next;
	logic [CODE_W-1:0] last_next;

	assign pin = item.pin_level;
	assign burst_ok = in_window(item.elapsed_count, cfg.burst_min, cfg.burst_max);
	assign gap_ok = in_window(item.elapsed_count, cfg.gap_min, cfg.gap_max);
	assign rep_ok = in_window(item.elapsed_count, cfg.rep_min, cfg.rep_max);
	assign zero_ok = in_window(item.elapsed_count, cfg.zero_min, cfg.zero_max);
	assign cnt_inc = bit_count + CNT_W'(1);
	assign last_bit = cnt_inc >= CNT_W'(FRAME_BITS);

	always_comb begin
		state_next = ctx.state;
		if (item.req_type == REQ_TIMEOUT) begin
			state_next = ST_IDLE;
		end else begin
			unique case (ctx.state)
				ST_IDLE: if (!pin) state_next = ST_BURST;
				ST_BURST: if (pin && burst_ok) state_next = ST_GAP;
				ST_GAP: begin
					if (!pin) begin
						if (gap_ok) state_next = ST_DATA;
						else if (rep_ok) state_next = ST_IDLE;
					end
				end
				ST_DATA: if (!pin && last_bit) state_next = ST_FINISH;
				ST_FINISH: state_next = ST_IDLE;
				default: ;
			endcase
		end
	end

	always_comb begin
		shift_next = ctx.shift_bits;
		last_next = ctx.last_code;
		bit_count_next = bit_count;
		res_valid = 1'b0;
		res.frame_kind = KIND_DATA;
		res.raw_code = ctx.last_code;
		if (item.req_type == REQ_EDGE) begin
			unique case (ctx.state)
				ST_GAP: begin
					if (!pin) begin
						if (gap_ok) begin
							bit_count_next = '0;
							shift_next = '0;
						end else if (rep_ok) begin
							res_valid = 1'b1;
							res.frame_kind = KIND_REPEAT;
						end
					end
				end
				ST_DATA: begin
					if (!pin) begin
						shift_next = {ctx.shift_bits[CODE_W-2:0], !zero_ok};
						bit_count_next = cnt_inc;
					end
				end
				ST_FINISH: begin
					last_next = ctx.shift_bits;
					res_valid = 1'b1;
					res.raw_code = ctx.shift_bits;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		ctx_next.state = state_next;
		ctx_next.shift_bits = shift_next;
		ctx_next.last_code = last_next;
	end

endmodule

// ===== sv/nec_ir_frame_decoder_unit.sv =====
// Top level of the NEC IR frame decoder: input stage, decode state, result register.
//
//   channel  direction  payload                          transfer when
//   in       sink       req_type, pin_level, elapsed     in_valid & in_ready
//   out      source     frame_kind, raw_code             out_valid & out_ready
//   cfg      sink       cfg_index, cfg_data              cfg_valid & cfg_ready
//
// One item per clock, but for the stall below; an item waits in the input register and its
// result, if any, is loaded into the result register as the item leaves it.
// The decode state update is a single pass of compares and a shift per item.
// A full result register that is not taken stalls the input stage only when
// the waiting item produces a result. cfg_ready is always high.
// Reset clears the state to idle and loads the default timing windows.
module nec_ir_frame_decoder_unit #(
	parameter int FRAME_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input nir_pkg::nir_req_t in_item,
	output logic out_valid,
	input logic out_ready,
	output nir_pkg::nir_res_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [nir_pkg::TICK_W-1:0] cfg_data
);
	import nir_pkg::*;
	`include "nec_ir_frame_decoder_unit_defines.svh"

	localparam int CNT_W = $clog2(FRAME_BITS + 1);

	nir_cfg_t cfg;
	logic valid_s1;
	nir_req_t item_s1;
	nir_ctx_t ctx_q;
	nir_ctx_t ctx_next;
	logic [CNT_W-1:0] bit_count_q;
	logic [CNT_W-1:0] bit_count_next;
	logic res_valid;
	nir_res_t res;
	logic out_valid_q;
	nir_res_t out_item_q;
	logic advance;

	assign cfg_ready = 1'b1;

	nir_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	nir_step #(.FRAME_BITS(FRAME_BITS)) u_step (
		.cfg(cfg),
		.item(item_s1),
		.ctx(ctx_q),
		.bit_count(bit_count_q),
		.ctx_next(ctx_next),
		.bit_count_next(bit_count_next),
		.res_valid(res_valid),
		.res(res)
	);

	// advance the input stage unless its result has nowhere to go
	assign advance = valid_s1 && (!res_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state <= ST_IDLE;
			ctx_q.shift_bits <= '0;
			ctx_q.last_code <= '0;
			bit_count_q <= '0;
		end else if (advance) begin
			ctx_q <= ctx_next;
			bit_count_q <= bit_count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	`NIR_ASSERT(a_result_from_stage, (out_valid_q && !$past(out_valid_q)) |-> $past(valid_s1), "result appeared without a staged item")
	`NIR_ASSERT(a_count_in_range, (ctx_q.state == ST_DATA) |-> (bit_count_q < CNT_W'(FRAME_BITS)), "bit count ran past frame length in data state")
	`NIR_ASSERT(a_ready_implies_move, (in_ready && valid_s1) |-> advance, "input taken while staged item is held")
	`NIR_ASSERT_RST(a_reset_empty, !arst_n |=> (!out_valid_q && !valid_s1), "pipeline not empty in reset")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the NEC IR frame decoder: directed table, then random frames.
module testbench;
	import nir_pkg::*;

	localparam int FRAME_LEN = 32;
	localparam int ITEM_GOAL = 1050;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 3000;

	typedef struct packed {
		logic fixed;
		logic hit;
		nir_res_t res;
		nir_req_t req;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [0:24] = '{
		'{1'b1, 1'b0, '0, '{REQ_TIMEOUT, 1'b1, 16'hFFFF}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd0}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b1, 16'd8000}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b1, 16'd10000}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'hFFFF}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b1, 16'd8001}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b1, 16'd0}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd2500}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd2000}},
		'{1'b1, 1'b1, '{KIND_REPEAT, 32'd0}, '{REQ_EDGE, 1'b0, 16'd2001}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd0}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b1, 16'd9999}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd5000}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd4000}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd4001}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b1, 16'hFFFF}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd0}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd401}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd699}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd700}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'd400}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b0, 16'hFFFF}},
		'{1'b1, 1'b0, '0, '{REQ_TIMEOUT, 1'b0, 16'd0}},
		'{1'b0, 1'b0, '0, '{REQ_EDGE, 1'b1, 16'd5}},
		'{1'b1, 1'b0, '0, '{REQ_TIMEOUT, 1'b0, 16'd1234}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	nir_req_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	nir_res_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0] cfg_data = '0;

	nir_state_t dec_state = ST_IDLE;
	logic [6:0] bit_cnt = '0;
	logic [CODE_W-1:0] shift_reg = '0;
	logic [CODE_W-1:0] last_frame = '0;
	logic [TICK_W-1:0] win [0:(1 << CFG_IDX_W) - 1] = '{0: RST_BURST_MIN, 1: RST_BURST_MAX,
		2: RST_GAP_MIN, 3: RST_GAP_MAX, 4: RST_REP_MIN, 5: RST_REP_MAX,
		6: RST_ZERO_MIN, 7: RST_ZERO_MAX, default: '0};

	nir_res_t expected_codes [$];
	int mismatches = 0;
	int items_sent = 0;
	int codes_expected = 0;
	int codes_seen = 0;
	int repeats_seen = 0;
	int windows_loaded = 0;
	int idle_pct = 7;
	int stuck_cycles = 0;
	logic hold_req = 1'b0;

	nec_ir_frame_decoder_unit #(.FRAME_BITS(FRAME_LEN)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic strictly_between(input logic [TICK_W-1:0] t,
			input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] hi);
		return (t > lo) && (t < hi);
	endfunction

	function automatic logic decode_edge(input nir_req_t r, output nir_res_t res);
		logic [TICK_W-1:0] t;
		logic hit;
		t = r.elapsed_count;
		hit = 1'b0;
		res = '0;
		if (r.req_type == REQ_TIMEOUT) begin
			dec_state = ST_IDLE;
		end else begin
			case (dec_state)
				ST_IDLE: begin
					if (!r.pin_level)
						dec_state = ST_BURST;
				end
				ST_BURST: begin
					if (r.pin_level && strictly_between(t, win[CFG_BURST_MIN], win[CFG_BURST_MAX]))
						dec_state = ST_GAP;
				end
				ST_GAP: begin
					if (!r.pin_level) begin
						if (strictly_between(t, win[CFG_GAP_MIN], win[CFG_GAP_MAX])) begin
							dec_state = ST_DATA;
							bit_cnt = '0;
							shift_reg = '0;
						end else if (strictly_between(t, win[CFG_REP_MIN], win[CFG_REP_MAX])) begin
							dec_state = ST_IDLE;
							res.frame_kind = KIND_REPEAT;
							res.raw_code = last_frame;
							hit = 1'b1;
						end
					end
				end
				ST_DATA: begin
					if (!r.pin_level) begin
						shift_reg = {shift_reg[CODE_W-2:0],
							!strictly_between(t, win[CFG_ZERO_MIN], win[CFG_ZERO_MAX])};
						bit_cnt = bit_cnt + 7'd1;
						if (bit_cnt >= FRAME_LEN)
							dec_state = ST_FINISH;
					end
				end
				ST_FINISH: begin
					dec_state = ST_IDLE;
					last_frame = shift_reg;
					res.frame_kind = KIND_DATA;
					res.raw_code = last_frame;
					hit = 1'b1;
				end
				default: begin
				end
			endcase
		end
		return hit;
	endfunction

	function automatic logic [TICK_W-1:0] rnd_tick();
		return TICK_W'($urandom);
	endfunction

	function automatic logic [TICK_W-1:0] pick_in(input logic [TICK_W-1:0] lo,
			input logic [TICK_W-1:0] hi);
		int unsigned l;
		int unsigned h;
		l = lo;
		h = hi;
		if (h <= l + 1)
			return rnd_tick();
		return TICK_W'($urandom_range(l + 1, h - 1));
	endfunction

	function automatic logic [TICK_W-1:0] pick_out(input logic [TICK_W-1:0] lo,
			input logic [TICK_W-1:0] hi);
		int unsigned l;
		int unsigned h;
		l = lo;
		h = hi;
		if (h <= l + 1)
			return rnd_tick();
		if ($urandom_range(0, 1))
			return TICK_W'($urandom_range(0, l));
		return TICK_W'($urandom_range(h, 16'hFFFF));
	endfunction

	function automatic nir_req_t mk_req(input logic rtype, input logic pin,
			input logic [TICK_W-1:0] cnt);
		nir_req_t r;
		r.req_type = rtype;
		r.pin_level = pin;
		r.elapsed_count = cnt;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR: %s", msg);
	endtask

	task automatic offer(input nir_req_t r, input logic fixed, input logic fixed_hit,
			input nir_res_t fixed_res);
		nir_res_t res;
		logic hit;
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= r;
		do begin
			@(posedge clk);
		end while (!in_ready);
		hit = decode_edge(r, res);
		if (fixed) begin
			hit = fixed_hit;
			res = fixed_res;
		end
		if (hit) begin
			expected_codes.push_back(res);
			codes_expected++;
		end
		items_sent++;
	endtask

	task automatic put(input nir_req_t r);
		offer(r, 1'b0, 1'b0, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		if (idx <= CFG_ZERO_MAX)
			win[idx] = val;
	endtask

	task automatic load_windows(input nir_cfg_t c, input logic stray);
		drain();
		if (stray) begin
			cfg_write(CFG_ZERO_MAX + 8'd1, rnd_tick());
			cfg_write(CFG_IDX_W'($urandom_range(CFG_ZERO_MAX + 1, (1 << CFG_IDX_W) - 1)),
				rnd_tick());
		end
		cfg_write(CFG_BURST_MIN, c.burst_min);
		cfg_write(CFG_BURST_MAX, c.burst_max);
		cfg_write(CFG_GAP_MIN, c.gap_min);
		cfg_write(CFG_GAP_MAX, c.gap_max);
		cfg_write(CFG_REP_MIN, c.rep_min);
		cfg_write(CFG_REP_MAX, c.rep_max);
		cfg_write(CFG_ZERO_MIN, c.zero_min);
		cfg_write(CFG_ZERO_MAX, c.zero_max);
		cfg_valid <= 1'b0;
		windows_loaded++;
	endtask

	task automatic play_sequence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			if ($urandom_range(0, 1))
				put(mk_req(REQ_TIMEOUT, 1'($urandom), rnd_tick()));
			put(mk_req(REQ_EDGE, 1'b0, rnd_tick()));
			if ($urandom_range(0, 9) == 0)
				put(mk_req(REQ_EDGE, 1'b1, pick_out(win[CFG_BURST_MIN], win[CFG_BURST_MAX])));
			put(mk_req(REQ_EDGE, 1'b1, pick_in(win[CFG_BURST_MIN], win[CFG_BURST_MAX])));
			if (pick < 50) begin
				if ($urandom_range(0, 19) == 0)
					put(mk_req(REQ_EDGE, 1'b0, pick_out(win[CFG_GAP_MIN], win[CFG_GAP_MAX])));
				put(mk_req(REQ_EDGE, 1'b0, pick_in(win[CFG_GAP_MIN], win[CFG_GAP_MAX])));
				for (int b = 0; b < FRAME_LEN; b++) begin
					if ($urandom_range(0, 199) == 0) begin
						put(mk_req(REQ_TIMEOUT, 1'($urandom), rnd_tick()));
						break;
					end
					if ($urandom_range(0, 19) == 0)
						put(mk_req(REQ_EDGE, 1'b1, rnd_tick()));
					if ($urandom_range(0, 1))
						put(mk_req(REQ_EDGE, 1'b0, pick_in(win[CFG_ZERO_MIN], win[CFG_ZERO_MAX])));
					else
						put(mk_req(REQ_EDGE, 1'b0, pick_out(win[CFG_ZERO_MIN], win[CFG_ZERO_MAX])));
				end
				if ($urandom_range(0, 19) == 0)
					put(mk_req(REQ_TIMEOUT, 1'($urandom), rnd_tick()));
				else
					put(mk_req(REQ_EDGE, 1'($urandom), rnd_tick()));
			end else begin
				put(mk_req(REQ_EDGE, 1'b0, pick_in(win[CFG_REP_MIN], win[CFG_REP_MAX])));
			end
		end else begin
			repeat ($urandom_range(1, 6))
				put(mk_req(($urandom_range(0, 3) == 0) ? REQ_TIMEOUT : REQ_EDGE, 1'($urandom),
					rnd_tick()));
		end
	endtask

	task automatic run_random(input int budget);
		int target;
		target = items_sent + budget;
		while (items_sent < target)
			play_sequence();
	endtask

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_codes
		nir_res_t want;
		if (arst_n && out_valid && out_ready) begin
			codes_seen++;
			if (out_item.frame_kind == KIND_REPEAT)
				repeats_seen++;
			if (expected_codes.size() == 0) begin
				flag_error($sformatf("unexpected transfer: kind %0d raw_code %08h",
					out_item.frame_kind, out_item.raw_code));
			end else begin
				want = expected_codes.pop_front();
				if (out_item.frame_kind !== want.frame_kind || out_item.raw_code !== want.raw_code)
					flag_error($sformatf("kind %0d (exp %0d), raw_code %08h (exp %08h)",
						out_item.frame_kind, want.frame_kind, out_item.raw_code, want.raw_code));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", STUCK_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		nir_cfg_t w;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i])
			offer(DIR_TAB[i].req, DIR_TAB[i].fixed, DIR_TAB[i].hit, DIR_TAB[i].res);

		idle_pct = 0;
		load_windows('{RST_BURST_MIN, RST_BURST_MAX, RST_GAP_MIN, RST_GAP_MAX,
			RST_REP_MIN, RST_REP_MAX, RST_ZERO_MIN, RST_ZERO_MAX}, 1'b1);
		run_random(200);
		idle_pct = 7;

		load_windows('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0);
		run_random(150);

		load_windows('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0);
		run_random(100);

		load_windows('{16'd100, 16'd300, 16'd1000, 16'd3000,
			16'd2000, 16'd4000, 16'd50, 16'd80}, 1'b0);
		run_random(150);

		w.burst_min = TICK_W'($urandom_range(0, 60000));
		w.burst_max = w.burst_min + TICK_W'($urandom_range(0, 5000));
		w.gap_min = TICK_W'($urandom_range(0, 60000));
		w.gap_max = w.gap_min + TICK_W'($urandom_range(0, 5000));
		w.rep_min = TICK_W'($urandom_range(0, 60000));
		w.rep_max = w.rep_min + TICK_W'($urandom_range(0, 5000));
		w.zero_min = TICK_W'($urandom_range(0, 60000));
		w.zero_max = w.zero_min + TICK_W'($urandom_range(0, 5000));
		load_windows(w, 1'b1);
		run_random(200);

		load_windows('{RST_BURST_MIN, RST_BURST_MAX, RST_GAP_MIN, RST_GAP_MAX,
			RST_REP_MIN, RST_REP_MAX, RST_ZERO_MIN, RST_ZERO_MAX}, 1'b0);
		hold_req = 1'b1;
		while (items_sent < ITEM_GOAL)
			play_sequence();

		drain();
		$display("Covered %0d input items under %0d window settings", items_sent, windows_loaded + 1);
		$display("Checked %0d codes (%0d repeat), %0d mismatches", codes_seen, repeats_seen,
			mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
